@@ rtl/bsfd_pkg.sv @@
// Shared constants and result type for the byte-stuffed frame decoder.
package bsfd_pkg;

  localparam logic [7:0] DELIM     = 8'hC0;
  localparam logic [7:0] ESC       = 8'hDD;
  localparam logic [7:0] ESC_DELIM = 8'hDC;
  localparam logic [7:0] ESC_ESC   = 8'hDB;

  localparam int unsigned LenWidth = 10;
  localparam int unsigned LenMax   = 1023;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [7:0]          data_byte;
    logic [LenWidth-1:0] frame_length;
    logic                overflow;
  } result_t;

endpackage

@@ rtl/byte_stuffed_frame_decoder.sv @@
// Byte-stuffed frame decoder: hunts for delimiters, unescapes body bytes, reports frame end.
//
//   channel  | handshake                    | word
//   ---------+------------------------------+------------------------------------------
//   input    | in_valid_i / in_stall_o      | rx_byte_i
//   output   | out_valid_o / out_stall_i    | kind_o, data_byte_o, frame_length_o, overflow_o
//
// One word is taken every cycle while in_stall_o is low; any result is registered.
// The decode state is three flags and two counters updated in the accept cycle.
// An output register plus one skid register decouple the two sides, so a word is
// still taken while one result waits; in_stall_o rises only when both are full.
// Reset clears the decode state and both valid flags; no clearing pass is needed.
module byte_stuffed_frame_decoder
  import bsfd_pkg::*;
#(
  parameter int unsigned MAX_RAW_LEN = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                kind_o,
  output logic [7:0]          data_byte_o,
  output logic [LenWidth-1:0] frame_length_o,
  output logic                overflow_o
);

  localparam int unsigned CntWidth = $clog2(MAX_RAW_LEN + 1);
  localparam logic [CntWidth-1:0] CntMax = CntWidth'(MAX_RAW_LEN);

  logic                frame_open_q, frame_open_d;
  logic                esc_pend_q, esc_pend_d;
  logic [CntWidth-1:0] raw_cnt_q, raw_cnt_d;
  logic [CntWidth-1:0] dec_cnt_q, dec_cnt_d;
  logic                ovf_q, ovf_d;

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    emit_data;
  logic [7:0] emit_byte;
  logic [31:0] dec_ext;

  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    out_ready;

  assign accept    = in_valid_i && !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign dec_ext   = 32'(dec_cnt_q);

  always_comb begin
    frame_open_d = frame_open_q;
    esc_pend_d   = esc_pend_q;
    raw_cnt_d    = raw_cnt_q;
    dec_cnt_d    = dec_cnt_q;
    ovf_d        = ovf_q;
    res_valid    = 1'b0;
    emit_data    = 1'b0;
    emit_byte    = rx_byte_i;
    res          = '0;

    if (!frame_open_q) begin
      if (rx_byte_i == DELIM) begin
        frame_open_d = 1'b1;
        esc_pend_d   = 1'b0;
        raw_cnt_d    = '0;
        dec_cnt_d    = '0;
        ovf_d        = 1'b0;
      end
    end else if (rx_byte_i == DELIM) begin
      // Delimiters before the first body byte are skipped.
      if (raw_cnt_q != '0 || ovf_q) begin
        res_valid        = 1'b1;
        res.kind         = KIND_END;
        res.frame_length = (dec_ext > LenMax) ? LenWidth'(LenMax)
                                              : dec_ext[LenWidth-1:0];
        res.overflow     = ovf_q;
        frame_open_d     = 1'b0;
        esc_pend_d       = 1'b0;
        raw_cnt_d        = '0;
        dec_cnt_d        = '0;
        ovf_d            = 1'b0;
      end
    end else if (raw_cnt_q >= CntMax) begin
      ovf_d = 1'b1;
    end else begin
      raw_cnt_d = raw_cnt_q + 1'b1;
      if (esc_pend_q) begin
        esc_pend_d = 1'b0;
        if (rx_byte_i == ESC_DELIM) begin
          emit_data = 1'b1;
          emit_byte = DELIM;
        end else if (rx_byte_i == ESC_ESC) begin
          emit_data = 1'b1;
          emit_byte = ESC;
        end
      end else if (rx_byte_i == ESC) begin
        esc_pend_d = 1'b1;
      end else begin
        emit_data = 1'b1;
      end
    end

    if (emit_data) begin
      res_valid     = 1'b1;
      res.kind      = KIND_DATA;
      res.data_byte = emit_byte;
      if (dec_cnt_q < CntMax) begin
        dec_cnt_d = dec_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      esc_pend_q   <= 1'b0;
      raw_cnt_q    <= '0;
      dec_cnt_q    <= '0;
      ovf_q        <= 1'b0;
    end else if (accept) begin
      frame_open_q <= frame_open_d;
      esc_pend_q   <= esc_pend_d;
      raw_cnt_q    <= raw_cnt_d;
      dec_cnt_q    <= dec_cnt_d;
      ovf_q        <= ovf_d;
    end
  end

  // Output register with a skid word behind it.
  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_ready) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid_q <= accept && res_valid;
      end else if (accept && res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready) begin
        out_q <= skid_q;
      end
    end else if (out_ready) begin
      if (accept && res_valid) begin
        out_q <= res;
      end
    end else if (accept && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign data_byte_o    = out_q.data_byte;
  assign frame_length_o = out_q.frame_length;
  assign overflow_o     = out_q.overflow;

endmodule
